FILE: design/lsd_pkg.sv
// Shared types, constants and code functions for the low speed data codec.
`default_nettype none
package lsd_pkg;

  localparam int unsigned NUM_LANES = 2;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned CW_W      = 16;
  localparam int unsigned LIMIT_W   = 5;
  localparam int unsigned CNT_W     = 5;

  localparam logic [LIMIT_W-1:0] ERR_LIMIT_RST = 5'd4;
  localparam logic [DATA_W-1:0]  LAST_CAND     = 8'hFF;

  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  localparam logic [DATA_W-1:0] GEN_ROWS [DATA_W] = '{
    8'h39, 8'h72, 8'hE4, 8'hF1, 8'hDB, 8'h8F, 8'h27, 8'h4E
  };

  typedef struct packed {
    logic        op;
    logic [31:0] received_word;
  } in_t;

  typedef struct packed {
    logic [31:0] result_word;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic        first_matched;
    logic        second_matched;
  } out_t;

  typedef struct packed {
    logic            done;
    logic            matched;
    logic [CW_W-1:0] word;
  } lane_res_t;

  function automatic logic [DATA_W-1:0] parity_of(input logic [DATA_W-1:0] d);
    logic [DATA_W-1:0] p;
    p = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (d[i]) begin
        p = p ^ GEN_ROWS[i];
      end
    end
    return p;
  endfunction

  function automatic logic [CNT_W-1:0] popcount16(input logic [CW_W-1:0] v);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < CW_W; i++) begin
      c = c + CNT_W'(v[i]);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: design/lsd_lane.sv
// One decode lane: sweeps candidate bytes and keeps the first close codeword.
`default_nettype none
module lsd_lane (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [15:0]                 cw,
  input  wire [4:0]                  limit,
  output lsd_pkg::lane_res_t         res
);
  import lsd_pkg::*;

  logic [CW_W-1:0]   cw_r, cw_nxt;
  logic [DATA_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              matched_r, matched_nxt;
  logic [CW_W-1:0]   word_r, word_nxt;
  logic [CW_W-1:0]   cand;
  logic              hit;

  assign cand = {cnt_r, parity_of(cnt_r)};
  assign hit  = popcount16(cand ^ cw_r) < limit;

  always_comb begin
    cw_nxt      = cw_r;
    cnt_nxt     = cnt_r;
    busy_nxt    = busy_r;
    done_nxt    = done_r;
    matched_nxt = matched_r;
    word_nxt    = word_r;
    if (start) begin
      cw_nxt   = cw;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (hit) begin
        word_nxt    = cand;
        matched_nxt = 1'b1;
        done_nxt    = 1'b1;
        busy_nxt    = 1'b0;
      end else if (cnt_r == LAST_CAND) begin
        word_nxt    = cw_r;
        matched_nxt = 1'b0;
        done_nxt    = 1'b1;
        busy_nxt    = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cw_r      <= cw_nxt;
    cnt_r     <= cnt_nxt;
    matched_r <= matched_nxt;
    word_r    <= word_nxt;
  end

  assign res = '{done: done_r, matched: matched_r, word: word_r};

endmodule
`default_nettype wire

FILE: design/lsd_merge.sv
// Merge stage: joins lane results or encodes stored bytes into the output register.
`default_nettype none
module lsd_merge (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 load,
  input  wire                 op,
  input  lsd_pkg::lane_res_t  res_hi,
  input  lsd_pkg::lane_res_t  res_lo,
  output logic                can_load,
  output logic                out_valid,
  input  wire                 out_ready,
  output lsd_pkg::out_t       out_data
);
  import lsd_pkg::*;

  logic [DATA_W-1:0] stored_first_r, stored_first_nxt;
  logic [DATA_W-1:0] stored_second_r, stored_second_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;
  logic [CW_W-1:0]   hi, lo;

  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    stored_first_nxt  = stored_first_r;
    stored_second_nxt = stored_second_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_nxt           = out_r;
    if (op == OP_DECODE) begin
      hi = res_hi.word;
      lo = res_lo.word;
    end else begin
      hi = {stored_first_r, parity_of(stored_first_r)};
      lo = {stored_second_r, parity_of(stored_second_r)};
    end
    if (load) begin
      out_valid_nxt          = 1'b1;
      out_nxt.result_word    = {hi, lo};
      out_nxt.first_data     = hi[CW_W-1:DATA_W];
      out_nxt.second_data    = lo[CW_W-1:DATA_W];
      out_nxt.first_matched  = (op == OP_DECODE) && res_hi.matched;
      out_nxt.second_matched = (op == OP_DECODE) && res_lo.matched;
      if (op == OP_DECODE) begin
        stored_first_nxt  = hi[CW_W-1:DATA_W];
        stored_second_nxt = lo[CW_W-1:DATA_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      stored_first_r  <= '0;
      stored_second_r <= '0;
    end else begin
      out_valid_r     <= out_valid_nxt;
      stored_first_r  <= stored_first_nxt;
      stored_second_r <= stored_second_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: design/lsd_cyclic_16_8_codec.sv
// Top level of the (16,8) cyclic low speed data codec.
// Usage:
//   Input channel in_valid/in_ready/in_data carries op and a 32-bit word of
//   two codewords (data1, parity1, data2, parity2 from the top byte down).
//   Decode (op 0) corrects each codeword in its own lane; encode (op 1)
//   rebuilds both codewords from the bytes stored by the last decode.
//   Output channel out_valid/out_ready/out_data returns one transaction per
//   input transaction, in order.
//   cfg_we/cfg_wdata writes error_limit; write it only while idle.
// Timing:
//   One transaction at a time. Each lane tests one candidate byte per cycle,
//   so decode time is set by the position of the first accepted candidate
//   in the 256-entry sweep; encode skips the sweep and goes straight to the
//   output load. in_ready is high again the cycle after the result loads.
//   A result waiting in the output register does not block the next accept;
//   only a finished sweep or an encode waits for that register to free up.
// Reset: synchronous, active low; clears control, stored bytes to zero and
//   error_limit to 4.
`default_nettype none
module lsd_cyclic_16_8_codec (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  lsd_pkg::in_t        in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output lsd_pkg::out_t       out_data,
  input  wire                 cfg_we,
  input  wire [4:0]           cfg_wdata
);
  import lsd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic               op_r, op_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic               accept;
  logic               start;
  logic               load;
  logic               can_load;
  lane_res_t          res [NUM_LANES];

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign start    = accept && (in_data.op == OP_DECODE);
  assign load     = (state_r == ST_DONE) && can_load;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = in_data.op;
          state_nxt = (in_data.op == OP_DECODE) ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (res[0].done && res[1].done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (can_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      limit_r <= ERR_LIMIT_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
    op_r <= op_nxt;
  end

  lsd_lane u_lane_hi (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cw    (in_data.received_word[31:16]),
    .limit (limit_r),
    .res   (res[0])
  );

  lsd_lane u_lane_lo (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cw    (in_data.received_word[15:0]),
    .limit (limit_r),
    .res   (res[1])
  );

  lsd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .op        (op_r),
    .res_hi    (res[0]),
    .res_lo    (res[1]),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: design/lsd_chk.sv
// Port-level checker for the codec, bound to the top level.
`default_nettype none
module lsd_chk (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input lsd_pkg::out_t       out_data
);
  import lsd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a transaction while busy");

  a_data_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.first_data == out_data.result_word[31:24] &&
                  out_data.second_data == out_data.result_word[15:8])
    else $error("data bytes disagree with result word");

  a_hi_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.first_matched |->
      out_data.result_word[23:16] == parity_of(out_data.result_word[31:24]))
    else $error("matched first codeword has bad parity");

  a_lo_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.second_matched |->
      out_data.result_word[7:0] == parity_of(out_data.result_word[15:8]))
    else $error("matched second codeword has bad parity");

endmodule

bind lsd_cyclic_16_8_codec lsd_chk u_lsd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
